### sv/mfxd_pkg.sv
`default_nettype none
package mfxd_pkg;

    localparam int MaxPayloadDefault = 64;

    localparam logic [7:0] StartMarkerReset = 8'hAA;
    localparam logic [7:0] EndMarkerReset = 8'h55;
    localparam logic [6:0] PayloadLengthReset = 7'd32;

    localparam logic [1:0] RegStartMarker = 2'd0;
    localparam logic [1:0] RegEndMarker = 2'd1;
    localparam logic [1:0] RegPayloadLength = 2'd2;

    localparam logic KindPayload = 1'b0;
    localparam logic KindStatus = 1'b1;

    localparam logic [1:0] StatusOk = 2'd0;
    localparam logic [1:0] StatusChecksum = 2'd1;
    localparam logic [1:0] StatusBadEnd = 2'd2;

    typedef struct packed {
        logic [7:0] sof_marker;
        logic [7:0] end_marker;
        logic [6:0] payload_length;
    } t_cfg;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        logic [5:0] payload_index;
        logic [1:0] frame_status;
        logic [7:0] sent_checksum;
        logic [7:0] computed_checksum;
    } t_result;

endpackage
`default_nettype wire

### sv/mfxd_cfg_regs.sv
`default_nettype none
module mfxd_cfg_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    output mfxd_pkg::t_cfg   o_cfg
);
    import mfxd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                RegStartMarker:   n_cfg.sof_marker = i_cfg_data;
                RegEndMarker:     n_cfg.end_marker = i_cfg_data;
                RegPayloadLength: n_cfg.payload_length = i_cfg_data[6:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sof_marker <= StartMarkerReset;
            r_cfg.end_marker <= EndMarkerReset;
            r_cfg.payload_length <= PayloadLengthReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

### sv/mfxd_frame_core.sv
`default_nettype none
module mfxd_frame_core #(
    parameter int MAX_PAYLOAD = mfxd_pkg::MaxPayloadDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  mfxd_pkg::t_cfg   i_cfg,
    input  wire logic        i_fire,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    output mfxd_pkg::t_result o_res
);
    import mfxd_pkg::*;

    localparam int POS_W = $clog2(MAX_PAYLOAD + 2);
    localparam int LEN_W = (POS_W > 7) ? POS_W : 7;
    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PAYLOAD);

    logic             r_in_frame;
    logic             n_in_frame;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_xor;
    logic [7:0]       n_xor;
    logic [7:0]       r_held;
    logic [7:0]       n_held;

    logic [LEN_W-1:0] len_raw;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] pos_ext;

    always_comb begin
        len_raw = LEN_W'(i_cfg.payload_length);
        if (len_raw == '0) begin
            eff_len = LEN_W'(1);
        end else if (len_raw > MaxLen) begin
            eff_len = MaxLen;
        end else begin
            eff_len = len_raw;
        end
        pos_ext = LEN_W'(r_pos);
    end

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos = r_pos;
        n_xor = r_xor;
        n_held = r_held;
        o_res_valid = 1'b0;
        o_res = '0;
        if (i_fire) begin
            if (!r_in_frame) begin
                if (i_rx_byte == i_cfg.sof_marker) begin
                    n_in_frame = 1'b1;
                    n_pos = '0;
                    n_xor = '0;
                    n_held = '0;
                end
            end else if (pos_ext < eff_len) begin
                if (r_pos != '0) begin
                    n_xor = r_xor ^ i_rx_byte;
                end
                o_res_valid = 1'b1;
                o_res.item_kind = KindPayload;
                o_res.payload_byte = i_rx_byte;
                o_res.payload_index = pos_ext[5:0];
                n_pos = POS_W'(pos_ext + LEN_W'(1));
            end else if (pos_ext == eff_len) begin
                n_held = i_rx_byte;
                n_pos = POS_W'(pos_ext + LEN_W'(1));
            end else begin
                o_res_valid = 1'b1;
                o_res.item_kind = KindStatus;
                if (i_rx_byte != i_cfg.end_marker) begin
                    o_res.frame_status = StatusBadEnd;
                end else if (r_held != r_xor) begin
                    o_res.frame_status = StatusChecksum;
                end else begin
                    o_res.frame_status = StatusOk;
                end
                o_res.sent_checksum = r_held;
                o_res.computed_checksum = r_xor;
                n_in_frame = 1'b0;
                n_pos = '0;
                n_xor = '0;
                n_held = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos <= '0;
            r_xor <= '0;
            r_held <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos <= n_pos;
            r_xor <= n_xor;
            r_held <= n_held;
        end
    end
endmodule
`default_nettype wire

### sv/mfxd_out_buf.sv
`default_nettype none
module mfxd_out_buf (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  mfxd_pkg::t_result i_data,
    output logic              o_can_accept,
    output logic              o_valid,
    input  wire logic         i_ready,
    output mfxd_pkg::t_result o_data
);
    import mfxd_pkg::*;

    logic    r_main_valid;
    logic    n_main_valid;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_main;
    t_result n_main;
    t_result r_skid;
    t_result n_skid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main = r_main;
        n_skid = r_skid;
        if (!r_main_valid || i_ready) begin
            if (r_skid_valid) begin
                n_main = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_main = i_data;
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            n_skid = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_can_accept = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data = r_main;
endmodule
`default_nettype wire

### sv/marker_framed_xor_deframer.sv
// Output: each result is registered in the output buffer before it is shown.
// Throughput: one byte per cycle; a two-entry output buffer keeps input ready while a
// result waits, and input stalls only when both output entries are full.
// Reset: synchronous, active low; registers return to 0xAA, 0x55 and 32, and the
// receiver returns to hunting for the start marker with an empty output buffer.
`default_nettype none
module marker_framed_xor_deframer #(
    parameter int MAX_PAYLOAD = mfxd_pkg::MaxPayloadDefault
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_item_kind,
    output logic [7:0]      o_payload_byte,
    output logic [5:0]      o_payload_index,
    output logic [1:0]      o_frame_status,
    output logic [7:0]      o_sent_checksum,
    output logic [7:0]      o_computed_checksum
);
    import mfxd_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    t_result out_res;
    logic    core_valid;
    logic    in_fire;

    assign in_fire = i_in_valid && o_in_ready;

    mfxd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mfxd_frame_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fire      (in_fire),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    mfxd_out_buf u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (core_valid),
        .i_data       (core_res),
        .o_can_accept (o_in_ready),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (out_res)
    );

    assign o_item_kind = out_res.item_kind;
    assign o_payload_byte = out_res.payload_byte;
    assign o_payload_index = out_res.payload_index;
    assign o_frame_status = out_res.frame_status;
    assign o_sent_checksum = out_res.sent_checksum;
    assign o_computed_checksum = out_res.computed_checksum;
endmodule
`default_nettype wire

### bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mfxd_pkg::*;

    typedef logic [7:0] t_byte_queue[$];

    localparam logic [1:0] RegUnused = 2'd3;
    localparam int RandomBeats = 1750;
    localparam int CycleLimit = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_item_kind;
    logic [7:0] o_payload_byte;
    logic [5:0] o_payload_index;
    logic [1:0] o_frame_status;
    logic [7:0] o_sent_checksum;
    logic [7:0] o_computed_checksum;

    marker_framed_xor_deframer uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_item_kind         (o_item_kind),
        .o_payload_byte      (o_payload_byte),
        .o_payload_index     (o_payload_index),
        .o_frame_status      (o_frame_status),
        .o_sent_checksum     (o_sent_checksum),
        .o_computed_checksum (o_computed_checksum)
    );

    // Shadow copy of the receiver: registers and framing state.
    logic [7:0] start_reg = StartMarkerReset;
    logic [7:0] end_reg = EndMarkerReset;
    logic [6:0] len_reg = PayloadLengthReset;
    logic       in_frame = 1'b0;
    logic [6:0] byte_pos = '0;
    logic [7:0] frame_xor = '0;
    logic [7:0] held_check = '0;

    t_result expected_items[$];
    t_result want;

    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    int beats_sent = 0;
    int error_count = 0;
    int payload_seen = 0;
    int status_seen[3] = '{0, 0, 0};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CycleLimit) @(posedge i_clk);
        $display("tb_top: done, errors");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_ready <= !(stalls_on && $urandom_range(99) < 10);
    end

    function automatic logic [6:0] frame_length();
        if (len_reg == 7'd0) return 7'd1;
        if (len_reg > 7'(MaxPayloadDefault)) return 7'(MaxPayloadDefault);
        return len_reg;
    endfunction

    function automatic logic [7:0] xor_tail(input t_byte_queue body);
        logic [7:0] acc;
        acc = '0;
        for (int i = 1; i < body.size(); i++) acc ^= body[i];
        return acc;
    endfunction

    // Advances the shadow receiver by one byte and queues the result it yields.
    function automatic void deframe_byte(input logic [7:0] b);
        logic [6:0] eff;
        t_result r;
        eff = frame_length();
        r = '0;
        if (!in_frame) begin
            if (b == start_reg) begin
                in_frame = 1'b1;
                byte_pos = '0;
                frame_xor = '0;
                held_check = '0;
            end
        end else if (byte_pos < eff) begin
            if (byte_pos != 7'd0) frame_xor ^= b;
            r.item_kind = KindPayload;
            r.payload_byte = b;
            r.payload_index = byte_pos[5:0];
            expected_items.push_back(r);
            byte_pos++;
        end else if (byte_pos == eff) begin
            held_check = b;
            byte_pos++;
        end else begin
            r.item_kind = KindStatus;
            if (b != end_reg) r.frame_status = StatusBadEnd;
            else if (held_check != frame_xor) r.frame_status = StatusChecksum;
            else r.frame_status = StatusOk;
            r.sent_checksum = held_check;
            r.computed_checksum = frame_xor;
            expected_items.push_back(r);
            in_frame = 1'b0;
            byte_pos = '0;
            frame_xor = '0;
            held_check = '0;
        end
    endfunction

    task automatic compare_field(input string name, input logic [7:0] exp_v,
                                 input logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_items.size() == 0) begin
                $error("result beat arrived with nothing expected");
                error_count++;
            end else begin
                want = expected_items.pop_front();
                compare_field("item_kind", 8'(want.item_kind), 8'(o_item_kind));
                compare_field("payload_byte", want.payload_byte, o_payload_byte);
                compare_field("payload_index", 8'(want.payload_index), 8'(o_payload_index));
                compare_field("frame_status", 8'(want.frame_status), 8'(o_frame_status));
                compare_field("sent_checksum", want.sent_checksum, o_sent_checksum);
                compare_field("computed_checksum", want.computed_checksum,
                              o_computed_checksum);
                if (want.item_kind == KindPayload) payload_seen++;
                else if (want.frame_status <= StatusBadEnd) status_seen[want.frame_status]++;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (gaps_on && $urandom_range(99) < 10) ? $urandom_range(1, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        deframe_byte(b);
        beats_sent++;
    endtask

    task automatic send_frame(input t_byte_queue body, input logic [7:0] ck_byte,
                              input logic [7:0] tail);
        send_byte(start_reg);
        foreach (body[i]) send_byte(body[i]);
        send_byte(ck_byte);
        send_byte(tail);
    endtask

    // Stops sending, waits for every queued result, then lets the pipeline settle.
    task automatic settle_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_items.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            RegStartMarker: start_reg = data;
            RegEndMarker: end_reg = data;
            RegPayloadLength: len_reg = data[6:0];
            default: ;
        endcase
    endtask

    task automatic test_reset_config();
        t_byte_queue body;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(EndMarkerReset);
        body = {8'hFF, 8'h00};
        while (body.size() < 32) body.push_back(8'($urandom_range(255)));
        send_frame(body, xor_tail(body), end_reg);
        settle_results();
    endtask

    task automatic test_status_codes();
        write_reg(RegPayloadLength, 8'd2);
        // A start marker inside the frame is plain data.
        send_frame({start_reg, start_reg}, start_reg, end_reg);
        send_frame({8'h00, 8'hFF}, 8'h00, end_reg);
        send_frame({8'h01, 8'h02}, 8'h02, 8'h00);
        send_frame({8'h01, 8'h02}, 8'h7E, 8'hFF);
        settle_results();
    endtask

    task automatic test_length_limits();
        t_byte_queue body;
        write_reg(RegPayloadLength, 8'd0);
        send_frame({8'h7F}, 8'h00, end_reg);
        settle_results();
        write_reg(RegPayloadLength, 8'hC1);
        body = {8'hFF};
        while (body.size() < MaxPayloadDefault) body.push_back(8'($urandom_range(255)));
        send_frame(body, xor_tail(body), end_reg);
        settle_results();
        write_reg(RegPayloadLength, 8'd1);
        send_frame({8'h80}, 8'h01, end_reg);
        settle_results();
    endtask

    task automatic test_length_change_midframe();
        write_reg(RegPayloadLength, 8'd4);
        send_byte(start_reg);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        settle_results();
        // Shrunk below the position: the next byte closes the frame.
        write_reg(RegPayloadLength, 8'd2);
        send_byte(end_reg);
        send_byte(start_reg);
        send_byte(8'h44);
        send_byte(8'h55);
        settle_results();
        write_reg(RegPayloadLength, 8'd2);
        send_byte(8'h55);
        send_byte(end_reg);
        settle_results();
        write_reg(RegPayloadLength, 8'd1);
        send_byte(start_reg);
        send_byte(8'h01);
        settle_results();
        write_reg(RegPayloadLength, 8'd3);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'h01);
        send_byte(end_reg);
        settle_results();
    endtask

    task automatic test_unused_register();
        write_reg(RegUnused, 8'h00);
        send_frame({8'h5A, 8'hC3, 8'h3C}, 8'hFF, end_reg);
        settle_results();
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int phase;
        int phase_end;
        int lead;
        logic [7:0] b;
        logic [7:0] ck_byte;
        logic [7:0] tail;
        logic [7:0] len_data;
        t_byte_queue body;
        stop_at = beats_sent + RandomBeats;
        phase = 0;
        while (beats_sent < stop_at) begin
            settle_results();
            case (phase)
                0: begin
                    write_reg(RegStartMarker, 8'h00);
                    write_reg(RegEndMarker, 8'hFF);
                    len_data = 8'd64;
                end
                1: begin
                    write_reg(RegStartMarker, 8'hFF);
                    write_reg(RegEndMarker, 8'h00);
                    len_data = 8'hFF;
                end
                default: begin
                    write_reg(RegStartMarker, 8'($urandom_range(255)));
                    if ($urandom_range(99) < 10) write_reg(RegEndMarker, start_reg);
                    else write_reg(RegEndMarker, 8'($urandom_range(255)));
                    if (phase == 2) len_data = 8'd1;
                    else if (phase == 3) len_data = 8'd0;
                    else if ($urandom_range(99) < 80) len_data = 8'($urandom_range(1, 8));
                    else len_data = 8'($urandom_range(255));
                end
            endcase
            write_reg(RegPayloadLength, len_data);
            gaps_on = (phase != 4);
            stalls_on = (phase != 4);
            phase_end = beats_sent + 150;
            while (beats_sent < phase_end && beats_sent < stop_at) begin
                if ($urandom_range(99) < 85) begin
                    lead = $urandom_range(2);
                    repeat (lead) begin
                        do b = 8'($urandom_range(255)); while (b == start_reg);
                        send_byte(b);
                    end
                    body = {};
                    repeat (frame_length()) body.push_back(8'($urandom_range(255)));
                    ck_byte = xor_tail(body);
                    if ($urandom_range(99) < 15) ck_byte ^= 8'(1 << $urandom_range(7));
                    tail = end_reg;
                    if ($urandom_range(99) < 10) tail = 8'($urandom_range(255));
                    send_frame(body, ck_byte, tail);
                end else begin
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
                end
                if ($urandom_range(99) < 3) settle_results();
            end
            phase++;
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = RegStartMarker;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_rx_byte = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_config();
        test_status_codes();
        test_length_limits();
        test_length_change_midframe();
        test_unused_register();
        test_random_traffic();

        settle_results();
        repeat (8) @(posedge i_clk);
        $display("tb_top: %0d input beats, %0d payload results checked", beats_sent,
                 payload_seen);
        $display("tb_top: frame status ok %0d, checksum mismatch %0d, bad end %0d",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
